// ===== hdl/at_command_line_parser_defines.svh =====
// ---------------------------------------------------------------------------
// AT command line parser assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef AT_COMMAND_LINE_PARSER_DEFINES_SVH
`define AT_COMMAND_LINE_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define ACP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define ACP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ACP_ASSERT_SAME(lbl, ante, cons, msg)
`define ACP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/acp_pkg.sv =====
// ---------------------------------------------------------------------------
// AT command line parser package
// Widths, result kinds, keyword table and character helpers.
// ---------------------------------------------------------------------------
package acp_pkg;

  localparam int LINE_MAX = 32;
  localparam int LEN_W    = $clog2(LINE_MAX + 1);
  localparam int ADDR_W   = $clog2(LINE_MAX);
  localparam int KW_COUNT = 27;
  localparam int KW_CHARS = 5;
  localparam int KEY_SKIP = 3;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  localparam logic [2:0] KIND_OK      = 3'd0;
  localparam logic [2:0] KIND_SYNTAX  = 3'd1;
  localparam logic [2:0] KIND_COMMAND = 3'd2;
  localparam logic [2:0] KIND_UNKNOWN = 3'd3;
  localparam logic [2:0] KIND_TEXT    = 3'd4;

  localparam logic [2:0] ARG_NONE     = 3'd0;
  localparam logic [2:0] ARG_UNSIGNED = 3'd1;
  localparam logic [2:0] ARG_SIGNED   = 3'd2;
  localparam logic [2:0] ARG_SLOT     = 3'd3;
  localparam logic [2:0] ARG_KEY      = 3'd4;

  localparam logic [8*KW_CHARS-1:0] KW_STR [KW_COUNT] = '{
    "ID", "SAVE", "LOAD", "NEXT", "CLEAR", "LIST", "IDLE", "BM",
    "CL", "CR", "CM", "CD", "PL", "PR", "PM", "RL", "RR", "RM",
    "WU", "WD", "WS", "MX", "MY", "KW", "KP", "KR", "RA"
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{
    3'd2, 3'd4, 3'd4, 3'd4, 3'd5, 3'd4, 3'd4, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2
  };

  localparam logic [2:0] KW_ARG [KW_COUNT] = '{
    ARG_NONE, ARG_SLOT, ARG_SLOT, ARG_NONE, ARG_NONE, ARG_NONE, ARG_NONE,
    ARG_UNSIGNED, ARG_NONE, ARG_NONE, ARG_NONE, ARG_NONE, ARG_NONE,
    ARG_NONE, ARG_NONE, ARG_NONE, ARG_NONE, ARG_NONE, ARG_NONE, ARG_NONE,
    ARG_UNSIGNED, ARG_SIGNED, ARG_SIGNED, ARG_KEY, ARG_KEY, ARG_KEY,
    ARG_NONE
  };

  typedef struct packed {
    logic       hit;
    logic [4:0] code;
  } match_t;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) ? (c - 8'h20) : c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39);
  endfunction

  // Token bytes are shifted in, so the first character sits highest.
  function automatic match_t kw_lookup(input logic [8*KW_CHARS-1:0] tok,
                                       input logic [LEN_W-1:0] tok_len);
    match_t m;
    m = '0;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (tok_len == LEN_W'(KW_LEN[i]) && tok == KW_STR[i]) begin
        m.hit  = 1'b1;
        m.code = 5'(i);
      end
    end
    return m;
  endfunction

endpackage

// ===== hdl/acp_line_mem.sv =====
// ---------------------------------------------------------------------------
// Line buffer
// One write port and one registered read port for the command line bytes.
// ---------------------------------------------------------------------------
module acp_line_mem
  import acp_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wa,
  input  logic [7:0]        wd,
  input  logic [ADDR_W-1:0] ra,
  output logic [7:0]        rq
);

  logic [7:0] mem [LINE_MAX];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rq <= mem[ra];
  end

endmodule

// ===== hdl/acp_digit_unit.sv =====
// ---------------------------------------------------------------------------
// Decimal accumulate unit
// Computes mag * 10 + digit, saturated at 16 bits, once per argument byte.
// ---------------------------------------------------------------------------
module acp_digit_unit
  import acp_pkg::*;
(
  input  logic [15:0] mag,
  input  logic [7:0]  ch,
  output logic [15:0] mag_out
);

  logic [19:0] sum;

  assign sum = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0} + {16'd0, ch[3:0]};
  assign mag_out = (sum > 20'd65535) ? 16'hffff : sum[15:0];

endmodule

// ===== hdl/at_command_line_parser.sv =====
// ---------------------------------------------------------------------------
// AT command line parser
// Bytes enter on the input channel one transfer at a time. An "AT" prefix
// followed by CR or LF gives an ok result, by another non-space byte a
// syntax error; after "AT " the bytes are buffered until CR, LF or a full
// line. The line is then scanned byte by byte through the line buffer's
// registered read port, the keyword is matched, the argument is
// accumulated by the decimal unit, and the results leave on the output
// channel: a command or unknown result, then any text bytes.
// Bytes that give no result leave in_ready high. After a line end the
// scan, field finish and match come before the first result; text results
// are then fetched and loaded in turn. in_ready is low from a line end or a
// prefix reply until the last result of that byte has been loaded into the
// output register. The output register holds a result until its transfer;
// a stalled receiver holds up the sequencer but loses nothing. Reset
// returns to waiting for "A" with an empty line; the buffer is not cleared.
// ---------------------------------------------------------------------------
`include "at_command_line_parser_defines.svh"

module at_command_line_parser
  import acp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [4:0]  command_code,
  output logic signed [15:0] argument_value,
  output logic [7:0]  text_byte,
  output logic        last
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_EMIT1  = 4'd1;
  localparam logic [3:0] S_SCAN_A = 4'd2;
  localparam logic [3:0] S_SCAN_B = 4'd3;
  localparam logic [3:0] S_FIN    = 4'd4;
  localparam logic [3:0] S_MATCH  = 4'd5;
  localparam logic [3:0] S_CMD    = 4'd6;
  localparam logic [3:0] S_TXT_A  = 4'd7;
  localparam logic [3:0] S_TXT_B  = 4'd8;

  localparam logic [1:0] PH_A    = 2'd0;
  localparam logic [1:0] PH_T    = 2'd1;
  localparam logic [1:0] PH_AT   = 2'd2;
  localparam logic [1:0] PH_LINE = 2'd3;

  localparam logic [2:0] SUB_LEAD = 3'd0;
  localparam logic [2:0] SUB_TOK  = 3'd1;
  localparam logic [2:0] SUB_GAP  = 3'd2;
  localparam logic [2:0] SUB_ARG  = 3'd3;
  localparam logic [2:0] SUB_REST = 3'd4;

  logic [3:0]        st;
  logic [1:0]        phase;
  logic [LEN_W-1:0]  line_length;
  logic [2:0]        pend_kind;
  logic [LEN_W-1:0]  p, end_p, tok_s, tok_e, arg_s, arg_e, ms, me;
  logic [2:0]        sub;
  logic [8*KW_CHARS-1:0] tok;
  logic [LEN_W-1:0]  tok_len;
  logic [15:0]       mag;
  logic              f_minus, first_digit, bad_rest, unknown;
  logic [4:0]        code;
  logic [15:0]       arg_val;

  logic              in_xfer, eol, store_we;
  logic [7:0]        q, up_q;
  logic [15:0]       mag_acc;
  match_t            mt;
  logic [2:0]        how;
  logic [LEN_W-1:0]  alen;
  logic              valid_u, valid_s, neg, bad_num;
  logic [15:0]       neg_mag, num_val;

  assign in_ready = (st == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign eol      = (rx_byte == CH_CR) || (rx_byte == CH_LF);
  assign store_we = in_xfer && (phase == PH_LINE) && !eol &&
                    (line_length < LEN_W'(LINE_MAX - 1));
  assign up_q     = to_upper(q);

  acp_line_mem u_mem (
    .clk (clk),
    .we  (store_we),
    .wa  (line_length[ADDR_W-1:0]),
    .wd  (rx_byte),
    .ra  (p[ADDR_W-1:0]),
    .rq  (q)
  );

  acp_digit_unit u_digit (
    .mag     (mag),
    .ch      (q),
    .mag_out (mag_acc)
  );

  always_comb begin
    mt      = kw_lookup(tok, tok_len);
    how     = KW_ARG[mt.code];
    alen    = arg_e - arg_s;
    valid_u = (alen != '0) && first_digit && !bad_rest;
    valid_s = !bad_rest && ((first_digit && alen != '0) ||
                            (f_minus && alen >= LEN_W'(2)));
    neg     = (how == ARG_SIGNED) && f_minus;
    neg_mag = (mag > 16'd32768) ? 16'd32768 : mag;
    if (neg) begin
      num_val = 16'd0 - neg_mag;
    end else begin
      num_val = (mag > 16'd32767) ? 16'd32767 : mag;
    end
    bad_num = ((how == ARG_UNSIGNED) && !valid_u) ||
              ((how == ARG_SIGNED) && !valid_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st          <= S_IDLE;
      phase       <= PH_A;
      line_length <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (in_xfer) begin
            case (phase)
              PH_A: begin
                if (to_upper(rx_byte) == 8'h41) phase <= PH_T;
              end
              PH_T: begin
                phase <= (to_upper(rx_byte) == 8'h54) ? PH_AT : PH_A;
              end
              PH_AT: begin
                if (eol) begin
                  pend_kind <= KIND_OK;
                  st        <= S_EMIT1;
                  phase     <= PH_A;
                end else if (rx_byte == CH_SPACE) begin
                  line_length <= '0;
                  phase       <= PH_LINE;
                end else begin
                  pend_kind <= KIND_SYNTAX;
                  st        <= S_EMIT1;
                  phase     <= PH_A;
                end
              end
              default: begin
                if (eol || line_length >= LEN_W'(LINE_MAX - 1)) begin
                  phase <= PH_A;
                  p     <= '0;
                  sub   <= SUB_LEAD;
                  st    <= S_SCAN_A;
                end else begin
                  line_length <= line_length + LEN_W'(1);
                end
              end
            endcase
          end
        end
        S_EMIT1: begin
          if (!out_valid) begin
            out_valid      <= 1'b1;
            kind           <= pend_kind;
            command_code   <= '0;
            argument_value <= '0;
            text_byte      <= '0;
            last           <= 1'b1;
            st             <= S_IDLE;
          end
        end
        S_SCAN_A: begin
          st <= (p == line_length) ? S_FIN : S_SCAN_B;
        end
        S_SCAN_B: begin
          // A stored zero byte ends the line content.
          if (q == 8'd0) begin
            st <= S_FIN;
          end else begin
            p  <= p + LEN_W'(1);
            st <= S_SCAN_A;
            case (sub)
              SUB_LEAD: begin
                if (q != CH_SPACE) begin
                  tok_s   <= p;
                  tok     <= {{(8*KW_CHARS-8){1'b0}}, up_q};
                  tok_len <= LEN_W'(1);
                  sub     <= SUB_TOK;
                end
              end
              SUB_TOK: begin
                if (q == CH_SPACE) begin
                  tok_e <= p;
                  sub   <= SUB_GAP;
                end else begin
                  if (tok_len < LEN_W'(KW_CHARS)) tok <= {tok[8*KW_CHARS-9:0], up_q};
                  tok_len <= tok_len + LEN_W'(1);
                end
              end
              SUB_GAP: begin
                if (q != CH_SPACE) begin
                  arg_s       <= p;
                  sub         <= SUB_ARG;
                  f_minus     <= (q == CH_MINUS);
                  first_digit <= is_digit(q);
                  bad_rest    <= 1'b0;
                  mag         <= is_digit(q) ? {12'd0, q[3:0]} : 16'd0;
                end
              end
              SUB_ARG: begin
                if (q == CH_SPACE) begin
                  arg_e <= p;
                  sub   <= SUB_REST;
                end else begin
                  if (!is_digit(q)) bad_rest <= 1'b1;
                  mag <= mag_acc;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_FIN: begin
          end_p <= p;
          st    <= S_MATCH;
          case (sub)
            SUB_LEAD: begin
              tok_s   <= p;
              tok_e   <= p;
              tok_len <= '0;
              arg_s   <= p;
              arg_e   <= p;
            end
            SUB_TOK: begin
              tok_e <= p;
              arg_s <= p;
              arg_e <= p;
            end
            SUB_GAP: begin
              arg_s <= p;
              arg_e <= p;
            end
            SUB_ARG: begin
              arg_e <= p;
            end
            default: begin
            end
          endcase
        end
        S_MATCH: begin
          unknown <= !mt.hit || (tok_len == '0) || bad_num;
          code    <= mt.code;
          arg_val <= (how == ARG_UNSIGNED || how == ARG_SIGNED) ? num_val : 16'd0;
          if (how == ARG_SLOT) begin
            ms <= arg_s;
            me <= arg_e;
          end else if (how == ARG_KEY && tok_e < end_p) begin
            ms <= tok_s + LEN_W'(KEY_SKIP);
            me <= end_p;
          end else begin
            ms <= '0;
            me <= '0;
          end
          st <= S_CMD;
        end
        S_CMD: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            text_byte <= '0;
            p         <= ms;
            if (unknown) begin
              kind           <= KIND_UNKNOWN;
              command_code   <= '0;
              argument_value <= '0;
              last           <= 1'b1;
              st             <= S_IDLE;
            end else begin
              kind           <= KIND_COMMAND;
              command_code   <= code;
              argument_value <= arg_val;
              last           <= (ms >= me);
              st             <= (ms >= me) ? S_IDLE : S_TXT_A;
            end
          end
        end
        S_TXT_A: begin
          st <= S_TXT_B;
        end
        S_TXT_B: begin
          if (!out_valid) begin
            out_valid      <= 1'b1;
            kind           <= KIND_TEXT;
            command_code   <= '0;
            argument_value <= '0;
            text_byte      <= q;
            last           <= (p + LEN_W'(1) == me);
            p              <= p + LEN_W'(1);
            st             <= (p + LEN_W'(1) == me) ? S_IDLE : S_TXT_A;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  `ACP_ASSERT_NEXT(a_eol_starts_scan, in_xfer && phase == PH_LINE && eol, st == S_SCAN_A, "line end did not start the scan")
  `ACP_ASSERT_SAME(a_scan_in_line, st == S_SCAN_A || st == S_SCAN_B, p <= line_length, "scan pointer ran past the line")
  `ACP_ASSERT_SAME(a_text_in_range, st == S_TXT_B, p < me, "text pointer ran past the text end")

endmodule

// ===== verif/at_command_line_parser_tb.sv =====
// ---------------------------------------------------------------------------
// AT command line parser testbench
// Drives byte streams with random gaps into the parser and predicts every
// result with a behavioral model of the line parser; each result transfer is
// compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module at_command_line_parser_tb;
  import acp_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    logic [4:0]  code;
    logic [15:0] arg;
    logic [7:0]  text;
    logic        last;
  } reply_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  kind;
  logic [4:0]  command_code;
  logic signed [15:0] argument_value;
  logic [7:0]  text_byte;
  logic        last;

  reply_t      pending_replies[$];
  int          error_count = 0;
  int          idle_cycles = 0;
  int          sent_count = 0;
  bit          sender_quiet = 0;
  bit          receiver_quiet = 0;
  bit          hold_receiver = 0;

  // Predictor state.
  logic [1:0]  prefix_phase;
  int          buf_len;
  logic [7:0]  line_buf[LINE_MAX];

  string kw_names[KW_COUNT] = '{"ID", "SAVE", "LOAD", "NEXT", "CLEAR", "LIST",
    "IDLE", "BM", "CL", "CR", "CM", "CD", "PL", "PR", "PM", "RL", "RR", "RM",
    "WU", "WD", "WS", "MX", "MY", "KW", "KP", "KR", "RA"};
  logic [2:0] kw_args[KW_COUNT] = '{ARG_NONE, ARG_SLOT, ARG_SLOT, ARG_NONE,
    ARG_NONE, ARG_NONE, ARG_NONE, ARG_UNSIGNED, ARG_NONE, ARG_NONE, ARG_NONE,
    ARG_NONE, ARG_NONE, ARG_NONE, ARG_NONE, ARG_NONE, ARG_NONE, ARG_NONE,
    ARG_NONE, ARG_NONE, ARG_UNSIGNED, ARG_SIGNED, ARG_SIGNED, ARG_KEY, ARG_KEY,
    ARG_KEY, ARG_NONE};

  at_command_line_parser dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .rx_byte(rx_byte), .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .command_code(command_code), .argument_value(argument_value),
    .text_byte(text_byte), .last(last)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic reply_t make_reply(logic [2:0] k, logic [4:0] c,
                                        logic [15:0] a, logic [7:0] t);
    reply_t r;
    r.kind = k; r.code = c; r.arg = a; r.text = t; r.last = 1'b0;
    return r;
  endfunction

  function automatic int find_keyword(int s, int e);
    int hit;
    bit same;
    hit = -1;
    for (int i = 0; i < KW_COUNT; i++) begin
      if (hit < 0 && kw_names[i].len() == e - s) begin
        same = 1;
        for (int j = 0; j < e - s; j++)
          if (upcase(line_buf[s + j]) != kw_names[i][j]) same = 0;
        if (same) hit = i;
      end
    end
    return hit;
  endfunction

  function automatic bit decode_number(int s, int e, bit signed_ok,
                                       output logic [15:0] val);
    bit neg;
    int mag;
    neg = 0;
    mag = 0;
    val = '0;
    if (s < e && signed_ok && line_buf[s] == CH_MINUS) begin
      neg = 1;
      s++;
    end
    if (s >= e) return 0;
    for (int i = s; i < e; i++) begin
      if (line_buf[i] < "0" || line_buf[i] > "9") return 0;
      mag = mag * 10 + (line_buf[i] - "0");
      if (mag > 65535) mag = 65535;
    end
    if (neg) val = 16'(65536 - ((mag > 32768) ? 32768 : mag));
    else val = 16'((mag > 32767) ? 32767 : mag);
    return 1;
  endfunction

  task automatic parse_line(ref reply_t res[$]);
    int len, p, ts, te, as, ae, ms, me, code;
    logic [15:0] val;
    logic [2:0] how;
    len = buf_len;
    for (int i = 0; i < buf_len; i++)
      if (line_buf[i] == 8'd0 && len == buf_len) len = i;
    p = 0;
    while (p < len && line_buf[p] == CH_SPACE) p++;
    ts = p;
    while (p < len && line_buf[p] != CH_SPACE) p++;
    te = p;
    code = (ts < te) ? find_keyword(ts, te) : -1;
    if (code < 0) begin
      res.push_back(make_reply(KIND_UNKNOWN, 0, 0, 0));
      return;
    end
    while (p < len && line_buf[p] == CH_SPACE) p++;
    as = p;
    while (p < len && line_buf[p] != CH_SPACE) p++;
    ae = p;
    how = kw_args[code];
    val = '0;
    if (how == ARG_UNSIGNED || how == ARG_SIGNED) begin
      if (!decode_number(as, ae, how == ARG_SIGNED, val)) begin
        res.push_back(make_reply(KIND_UNKNOWN, 0, 0, 0));
        return;
      end
    end
    res.push_back(make_reply(KIND_COMMAND, 5'(code), val, 0));
    ms = 0;
    me = 0;
    if (how == ARG_SLOT) begin
      ms = as; me = ae;
    end else if (how == ARG_KEY && te < len) begin
      ms = ts + KEY_SKIP; me = len;
    end
    for (int i = ms; i < me && res.size() < 32; i++)
      res.push_back(make_reply(KIND_TEXT, 0, 0, line_buf[i]));
  endtask

  task automatic predict_byte(logic [7:0] b);
    reply_t res[$];
    bit eol;
    eol = (b == CH_CR || b == CH_LF);
    case (prefix_phase)
      2'd0: if (b == "A" || b == "a") prefix_phase = 2'd1;
      2'd1: prefix_phase = (b == "T" || b == "t") ? 2'd2 : 2'd0;
      2'd2: begin
        if (eol) res.push_back(make_reply(KIND_OK, 0, 0, 0));
        else if (b == CH_SPACE) buf_len = 0;
        else res.push_back(make_reply(KIND_SYNTAX, 0, 0, 0));
        prefix_phase = (!eol && b == CH_SPACE) ? 2'd3 : 2'd0;
      end
      default: begin
        if (eol || buf_len >= LINE_MAX - 1) begin
          parse_line(res);
          prefix_phase = 2'd0;
        end else begin
          line_buf[buf_len] = b;
          buf_len++;
        end
      end
    endcase
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) pending_replies.push_back(res[i]);
  endtask

  // Sends one byte; the prediction is made once the transfer happens.
  // Valid stays high into the next byte unless the sender idles.
  task automatic send_byte(logic [7:0] b);
    while (!sender_quiet && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line(string body, bit use_lf);
    send_text({"AT ", body});
    send_byte(use_lf ? CH_LF : CH_CR);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  always @(negedge clk)
    out_ready <= !hold_receiver && (receiver_quiet || $urandom_range(99) >= 33);

  always @(posedge clk) begin
    reply_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected result kind", kind, -1);
      end else begin
        want = pending_replies.pop_front();
        if (kind !== want.kind) report_mismatch("kind", kind, want.kind);
        if (command_code !== want.code)
          report_mismatch("command_code", command_code, want.code);
        if (argument_value !== want.arg)
          report_mismatch("argument_value", argument_value, $signed(want.arg));
        if (text_byte !== want.text)
          report_mismatch("text_byte", text_byte, want.text);
        if (last !== want.last) report_mismatch("last", last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || hold_receiver)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic test_prefix_cases();
    send_text("AT\r");
    send_text("at\n");
    send_text("aTx");
    send_text("Ab");
    send_line("", 0);
    send_line("   ", 1);
  endtask

  task automatic test_keywords();
    send_line("save slotA", 0);
    send_line("LOAD", 1);
    send_line("bm 65535", 0);
    send_line("WS 12x", 1);
    send_line("mx -99999", 0);
    send_line("MY -", 1);
    send_line("kw  KEY_A KEY_B", 0);
    send_line("KP", 1);
    send_line("idlex", 0);
  endtask

  task automatic test_special_bytes();
    send_text("AT ID");
    send_byte(8'd0);
    send_text("junk\r");
    // Fills the line so that the second-to-last 0xff byte ends it without being stored.
    send_text("AT KR ");
    for (int i = 0; i < 30; i++) send_byte(8'hff);
    send_text("AT ");
    for (int i = 0; i < 4; i++) send_byte(8'h00);
    send_byte(CH_CR);
  endtask

  function automatic string random_number(bit neg_ok);
    string s;
    s = "";
    if (neg_ok && $urandom_range(1)) s = "-";
    case ($urandom_range(3))
      0: s = {s, $sformatf("%0d", $urandom_range(9))};
      1: s = {s, $sformatf("%0d", $urandom_range(40000))};
      2: s = {s, $sformatf("%0d", $urandom)};
      default: if ($urandom_range(1)) s = {s, "1a"};
    endcase
    return s;
  endfunction

  function automatic string random_case(string s);
    string r;
    r = s;
    for (int i = 0; i < r.len(); i++)
      if (r[i] >= "A" && r[i] <= "Z" && $urandom_range(1)) r[i] = r[i] + 8'd32;
    return r;
  endfunction

  task automatic test_random_traffic(int upto);
    string body;
    int k;
    while (sent_count < upto) begin
      k = $urandom_range(KW_COUNT - 1);
      body = "";
      if ($urandom_range(3) == 0) body = " ";
      body = {body, random_case(kw_names[k])};
      if ($urandom_range(4) != 0) begin
        case (kw_args[k])
          ARG_UNSIGNED, ARG_SIGNED:
            body = {body, " ", random_number(kw_args[k] == ARG_SIGNED)};
          ARG_SLOT, ARG_KEY: body = {body, " ", random_case("Slot1 x")};
          default: ;
        endcase
      end
      case ($urandom_range(9))
        0: for (int i = 0; i < 6; i++) send_byte(8'($urandom));
        1: send_text("ATq");
        2: send_text("AT\r");
        default: send_line(body, $urandom_range(1));
      endcase
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_receiver = 1;
        repeat (400) @(negedge clk);
        hold_receiver = 0;
      end
      begin
        for (int i = 0; i < 2; i++) send_line("KW abcdefghij", 0);
        in_valid <= 1'b0;
      end
    join
  endtask

  initial begin
    int drain;
    prefix_phase = 2'd0;
    buf_len = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_prefix_cases();
    test_keywords();
    test_special_bytes();
    sender_quiet = 1;
    receiver_quiet = 1;
    test_random_traffic(200);
    sender_quiet = 0;
    receiver_quiet = 0;
    test_random_traffic(236);
    test_backpressure();
    drain = 0;
    while (pending_replies.size() != 0 && drain < 50000) begin
      @(posedge clk);
      drain++;
    end
    repeat (200) @(posedge clk);
    if (error_count == 0 && pending_replies.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
